FILE: rtl/gbn_pkg.sv
package gbn_pkg;

    // Default number of retransmit slots.
    localparam int SLOTS_DEF = 64;

    // The window never exceeds this many outstanding packets.
    localparam int WIN_CAP = 64;

    localparam int WIN_W    = 7;
    localparam int SEQ_W    = 32;
    localparam int TAG_W    = 32;
    localparam int LEN_W    = 16;

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);
    localparam logic [SEQ_W-1:0] SEQ_START = SEQ_W'(1);

    // Event codes of an input item.
    localparam logic [1:0] MODE_SEND    = 2'd0;
    localparam logic [1:0] MODE_ACK     = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;
    localparam logic [1:0] MODE_DATA    = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_TX_DATA = 2'd0;
    localparam logic [1:0] KIND_TX_ACK  = 2'd1;
    localparam logic [1:0] KIND_DELIVER = 2'd2;
    localparam logic [1:0] KIND_REFUSED = 2'd3;

    typedef struct packed {
        logic [1:0]       mode;
        logic [TAG_W-1:0] payload_tag;
        logic [LEN_W-1:0] payload_len;
        logic [SEQ_W-1:0] packet_seq;
        logic [SEQ_W-1:0] ack_number;
        logic             corrupt;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SEQ_W-1:0] seq_out;
        logic [SEQ_W-1:0] ack_out;
        logic [TAG_W-1:0] tag_out;
        logic [LEN_W-1:0] len_out;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
    } t_slot;

endpackage

FILE: rtl/go_back_n_endpoint.sv
// Go-Back-N endpoint. A send or data result passes through the pending stage into the
// output register; the ack after a delivery follows it. A timeout's resent items pass
// through the pending stage and slot memory read register, one per cycle while the output
// does not stall. Throughput: an item with no result every cycle; an item with results
// holds the input until all of them have entered the output register, plus output stalls.
// Reset (synchronous, active low): sequence numbers 1, window size 8; slots not cleared.
module go_back_n_endpoint #(
    parameter int SLOTS = gbn_pkg::SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  gbn_pkg::t_in_item         i_in_data,

    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output gbn_pkg::t_out_item        o_out_data,

    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [gbn_pkg::WIN_W-1:0] i_cfg_data
);

    // Slot index width, and one more bit for sums of two slot offsets.
    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW1 = SW + 1;
    localparam int EFF_MAX = (SLOTS < gbn_pkg::WIN_CAP) ? SLOTS : gbn_pkg::WIN_CAP;

    localparam logic [SW1-1:0]           SLOTS_V = SW1'(SLOTS);
    localparam logic [gbn_pkg::WIN_W-1:0] EFF_V  = gbn_pkg::WIN_W'(EFF_MAX);

    // The item flows through two result stages. The pending stage holds the next result;
    // the output register faces the consumer. During a timeout walk the pending stage
    // carries the sequence number and last flag while the slot memory read register carries
    // the payload, so one slot can be resent every cycle unless the output stalls.

    // Sender and receiver control state.
    logic [gbn_pkg::WIN_W-1:0] r_win_size, n_win_size;
    logic [gbn_pkg::SEQ_W-1:0] r_base, n_base;
    logic [gbn_pkg::SEQ_W-1:0] r_next_seq, n_next_seq;
    logic [gbn_pkg::SEQ_W-1:0] r_exp_seq, n_exp_seq;
    logic [SW-1:0]             r_base_slot, n_base_slot;
    // Number of unacknowledged packets, always next_seq - base.
    logic [gbn_pkg::WIN_W-1:0] r_outstanding, n_outstanding;

    // Timeout walk.
    logic [gbn_pkg::WIN_W-1:0] r_walk_rem, n_walk_rem;
    logic [gbn_pkg::SEQ_W-1:0] r_walk_seq, n_walk_seq;
    logic [SW-1:0]             r_walk_slot, n_walk_slot;

    // Second result of an in-order data arrival: the ack that follows the delivery.
    logic                      r_ack2, n_ack2;
    logic [gbn_pkg::SEQ_W-1:0] r_ack2_num, n_ack2_num;

    // Result stages.
    logic                      r_pnd_valid, n_pnd_valid;
    gbn_pkg::t_out_item        r_pnd, n_pnd;
    logic                      r_pnd_mem, n_pnd_mem;
    logic                      r_out_valid, n_out_valid;
    gbn_pkg::t_out_item        r_out, n_out;

    // Slot memory with a registered read port.
    gbn_pkg::t_slot            r_mem [SLOTS];
    gbn_pkg::t_slot            r_rd;

    logic                      busy;
    logic                      accept;
    logic                      move;
    logic                      pnd_free;
    logic                      walk_step;
    logic                      send_room;
    logic                      wr_en;
    logic [SW-1:0]             wr_slot;
    logic [SW1-1:0]            wr_sum;
    logic [gbn_pkg::WIN_W-1:0] eff_win;
    logic [gbn_pkg::SEQ_W-1:0] ack_dist;
    logic                      ack_ok;
    logic [SW1-1:0]            ack_sum;
    logic [gbn_pkg::SEQ_W-1:0] exp_prev;
    gbn_pkg::t_out_item        moved;

    // An item is taken only when no result of an earlier item is still waiting in the
    // pending stage; a result waiting in the output register does not hold the input.
    assign busy        = r_pnd_valid || r_ack2 || (r_walk_rem != '0);
    assign o_in_stall  = busy;
    assign o_cfg_ready = !busy;
    assign accept      = i_in_valid && !busy;

    assign move      = r_pnd_valid && (!r_out_valid || !i_out_stall);
    assign pnd_free  = !r_pnd_valid || move;
    assign walk_step = pnd_free && (r_walk_rem != '0) && !r_ack2;

    // Window size clamped to the number of slots and the window cap.
    assign eff_win   = (r_win_size > EFF_V) ? EFF_V : r_win_size;
    assign send_room = r_outstanding < eff_win;

    // The outstanding count is below the slot count whenever there is room, so one
    // conditional subtract brings the sum back into range.
    assign wr_sum  = SW1'(r_base_slot) + SW1'(r_outstanding);
    assign wr_slot = (wr_sum >= SLOTS_V) ? SW'(wr_sum - SLOTS_V) : SW'(wr_sum);
    assign wr_en   = accept && (i_in_data.mode == gbn_pkg::MODE_SEND) && send_room;

    // An ack counts only if it names one of the outstanding packets.
    assign ack_dist = i_in_data.ack_number - r_base;
    assign ack_ok   = !i_in_data.corrupt &&
                      (ack_dist < {{(gbn_pkg::SEQ_W-gbn_pkg::WIN_W){1'b0}}, r_outstanding});
    assign ack_sum  = SW1'(r_base_slot) + ack_dist[SW:0] + SW1'(1);

    assign exp_prev = r_exp_seq - gbn_pkg::SEQ_W'(1);

    always_comb begin
        moved = r_pnd;
        if (r_pnd_mem) begin
            moved.tag_out = r_rd.tag;
            moved.len_out = r_rd.len;
        end
    end

    always_comb begin
        n_win_size    = r_win_size;
        n_base        = r_base;
        n_next_seq    = r_next_seq;
        n_exp_seq     = r_exp_seq;
        n_base_slot   = r_base_slot;
        n_outstanding = r_outstanding;
        n_walk_rem    = r_walk_rem;
        n_walk_seq    = r_walk_seq;
        n_walk_slot   = r_walk_slot;
        n_ack2        = r_ack2;
        n_ack2_num    = r_ack2_num;
        n_pnd_valid   = r_pnd_valid && !move;
        n_pnd         = r_pnd;
        n_pnd_mem     = r_pnd_mem;
        n_out         = r_out;
        n_out_valid   = r_out_valid;

        if (i_cfg_valid && o_cfg_ready) begin
            n_win_size = i_cfg_data;
        end

        if (move) begin
            n_out       = moved;
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (accept) begin
            unique case (i_in_data.mode)
                gbn_pkg::MODE_SEND: begin
                    n_pnd_valid     = 1'b1;
                    n_pnd_mem       = 1'b0;
                    n_pnd.seq_out   = r_next_seq;
                    n_pnd.ack_out   = '0;
                    n_pnd.tag_out   = i_in_data.payload_tag;
                    n_pnd.len_out   = i_in_data.payload_len;
                    n_pnd.last      = 1'b1;
                    if (send_room) begin
                        n_pnd.kind    = gbn_pkg::KIND_TX_DATA;
                        n_next_seq    = r_next_seq + gbn_pkg::SEQ_W'(1);
                        n_outstanding = r_outstanding + gbn_pkg::WIN_W'(1);
                    end else begin
                        n_pnd.kind    = gbn_pkg::KIND_REFUSED;
                    end
                end
                gbn_pkg::MODE_ACK: begin
                    if (ack_ok) begin
                        n_base        = i_in_data.ack_number + gbn_pkg::SEQ_W'(1);
                        n_outstanding = r_outstanding - ack_dist[gbn_pkg::WIN_W-1:0]
                                        - gbn_pkg::WIN_W'(1);
                        n_base_slot   = (ack_sum >= SLOTS_V) ? SW'(ack_sum - SLOTS_V)
                                                             : SW'(ack_sum);
                    end
                end
                gbn_pkg::MODE_TIMEOUT: begin
                    n_walk_rem  = r_outstanding;
                    n_walk_seq  = r_base;
                    n_walk_slot = r_base_slot;
                end
                gbn_pkg::MODE_DATA: begin
                    if (!i_in_data.corrupt) begin
                        n_pnd_mem = 1'b0;
                        if (i_in_data.packet_seq == r_exp_seq) begin
                            n_pnd_valid   = 1'b1;
                            n_pnd.kind    = gbn_pkg::KIND_DELIVER;
                            n_pnd.seq_out = i_in_data.packet_seq;
                            n_pnd.ack_out = '0;
                            n_pnd.tag_out = i_in_data.payload_tag;
                            n_pnd.len_out = i_in_data.payload_len;
                            n_pnd.last    = 1'b0;
                            n_ack2        = 1'b1;
                            n_ack2_num    = r_exp_seq;
                            n_exp_seq     = r_exp_seq + gbn_pkg::SEQ_W'(1);
                        end else if (r_exp_seq > gbn_pkg::SEQ_W'(1)) begin
                            n_pnd_valid   = 1'b1;
                            n_pnd.kind    = gbn_pkg::KIND_TX_ACK;
                            n_pnd.seq_out = '0;
                            n_pnd.ack_out = exp_prev;
                            n_pnd.tag_out = '0;
                            n_pnd.len_out = '0;
                            n_pnd.last    = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (r_ack2 && pnd_free) begin
            n_ack2        = 1'b0;
            n_pnd_valid   = 1'b1;
            n_pnd_mem     = 1'b0;
            n_pnd.kind    = gbn_pkg::KIND_TX_ACK;
            n_pnd.seq_out = '0;
            n_pnd.ack_out = r_ack2_num;
            n_pnd.tag_out = '0;
            n_pnd.len_out = '0;
            n_pnd.last    = 1'b1;
        end else if (walk_step) begin
            // The slot is read at this edge; its payload joins the pending entry
            // from the read register when the entry moves on.
            n_pnd_valid   = 1'b1;
            n_pnd_mem     = 1'b1;
            n_pnd.kind    = gbn_pkg::KIND_TX_DATA;
            n_pnd.seq_out = r_walk_seq;
            n_pnd.ack_out = '0;
            n_pnd.tag_out = '0;
            n_pnd.len_out = '0;
            n_pnd.last    = (r_walk_rem == gbn_pkg::WIN_W'(1));
            n_walk_rem    = r_walk_rem - gbn_pkg::WIN_W'(1);
            n_walk_seq    = r_walk_seq + gbn_pkg::SEQ_W'(1);
            n_walk_slot   = (r_walk_slot == SW'(SLOTS - 1)) ? '0
                                                            : r_walk_slot + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size    <= gbn_pkg::WIN_RESET;
            r_base        <= gbn_pkg::SEQ_START;
            r_next_seq    <= gbn_pkg::SEQ_START;
            r_exp_seq     <= gbn_pkg::SEQ_START;
            r_base_slot   <= SW'(1 % SLOTS);
            r_outstanding <= '0;
            r_walk_rem    <= '0;
            r_walk_seq    <= gbn_pkg::SEQ_START;
            r_walk_slot   <= '0;
            r_ack2        <= 1'b0;
            r_pnd_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_win_size    <= n_win_size;
            r_base        <= n_base;
            r_next_seq    <= n_next_seq;
            r_exp_seq     <= n_exp_seq;
            r_base_slot   <= n_base_slot;
            r_outstanding <= n_outstanding;
            r_walk_rem    <= n_walk_rem;
            r_walk_seq    <= n_walk_seq;
            r_walk_slot   <= n_walk_slot;
            r_ack2        <= n_ack2;
            r_pnd_valid   <= n_pnd_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ack2_num <= n_ack2_num;
        r_pnd      <= n_pnd;
        r_pnd_mem  <= n_pnd_mem;
        r_out      <= n_out;
    end

    // Slot memory. Writes happen only for accepted sends, and no item is accepted
    // during a walk, so a read never meets a write to the same slot in one cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_slot] <= '{tag: i_in_data.payload_tag, len: i_in_data.payload_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (walk_step) begin
            r_rd <= r_mem[r_walk_slot];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The delivery ack and a timeout walk never overlap.
    a_ack2_no_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_walk_rem != '0) |-> !r_ack2)
        else $error("delivery ack pending during a timeout walk");

    // The outstanding count tracks the distance between next_seq and the window base.
    a_outstanding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_seq - r_base) == {{(gbn_pkg::SEQ_W-gbn_pkg::WIN_W){1'b0}}, r_outstanding})
        else $error("outstanding count out of step with sequence numbers");

    // No more packets are ever outstanding than there are slots.
    a_outstanding_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= EFF_V)
        else $error("outstanding count exceeds slot capacity");

    // A walk step always lands in a pending stage that is free at that edge.
    a_walk_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_step |=> (r_pnd_valid && r_pnd_mem))
        else $error("resent slot lost between memory read and pending stage");

endmodule
